[design/msd_pkg.sv]
package msd_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_PATH_FAIL  = 3'd1;
  localparam logic [2:0] CMD_COLLISION  = 3'd2;
  localparam logic [2:0] CMD_PROGRESS   = 3'd3;
  localparam logic [2:0] CMD_RESET      = 3'd4;
  localparam logic [2:0] CMD_CLEAR_HIST = 3'd5;

  // stall causes
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_POSITION  = 3'd1;
  localparam logic [2:0] KIND_PROGRESS  = 3'd2;
  localparam logic [2:0] KIND_PATH_FAIL = 3'd3;
  localparam logic [2:0] KIND_COLLISION = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRESS_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_FAIL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLLISION_LIMIT = 3'd5;

  // register reset values
  localparam logic [15:0] RST_CHECK_INTERVAL  = 16'd500;
  localparam logic [19:0] RST_POSITION_WINDOW = 20'd3000;
  localparam logic [11:0] RST_DIST_THRESHOLD  = 12'd32;
  localparam logic [19:0] RST_PROGRESS_TMO    = 20'd10000;
  localparam logic [7:0]  RST_PATH_FAIL_LIMIT = 8'd3;
  localparam logic [7:0]  RST_COLLISION_LIMIT = 8'd5;

  localparam logic [7:0]  COUNT_MAX     = 8'hFF;
  localparam logic [15:0] WAYPOINT_NONE = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        time_step_ms;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
    logic signed [23:0] position_z;
    logic               position_valid;
    logic [15:0]        waypoint_index;
  } cmd_t;

  typedef struct packed {
    logic        is_stuck;
    logic [2:0]  stuck_type;
    logic [31:0] stuck_duration;
    logic [7:0]  path_failures;
    logic [7:0]  collisions;
  } status_t;

  // one position sample of the history ring
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [31:0]        t;
  } sample_t;

endpackage

[design/msd_stream_if.sv]
interface msd_stream_if #(
  parameter type T = logic [0:0]
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/motion_stall_detector.sv]
// channel  | dir | payload  | transfer when
// ---------+-----+----------+------------------------------
// cmd      | in  | cmd_t    | cmd.valid && cmd.ready
// status   | out | status_t | status.valid && status.ready
// cfg      | in  | idx/data | cfg_we (no handshake)
//
// one item per cycle sustained while status is taken; an item passes the input
// register, then the result register; all its work sits between those two registers
// the history ring lives in a ram; its slot after the head is read ahead
// so the oldest sample is ready when the ring is full and rolls over
// rst is synchronous: control state and config return to defaults, ring
// contents are not cleared (the fill count hides them)
// a stalled status holds its result while the input register still takes
// one more item; cmd.ready drops only when both are full
module motion_stall_detector
  import msd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  msd_stream_if.sink           cmd,
  msd_stream_if.source         status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = $bits(sample_t);
  localparam logic [HW-1:0] HEAD_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(HISTORY_DEPTH);

  function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] i);
    wrap_inc = (i == HEAD_LAST) ? '0 : i + HW'(1);
  endfunction

  // configuration registers
  logic [15:0] check_interval_ms;
  logic [19:0] position_window_ms;
  logic [11:0] distance_threshold;
  logic [19:0] progress_timeout_ms;
  logic [7:0]  path_failure_limit;
  logic [7:0]  collision_limit;
  logic [23:0] thr_sq;

  // pipeline registers
  logic    s1_valid;
  cmd_t    s1_item;
  logic    out_valid;
  status_t out_item;
  logic    out_free;
  logic    go;

  // detector state
  logic [HW-1:0] hist_head, hist_head_next;
  logic [CW-1:0] hist_count, hist_count_next;
  logic [31:0]   total_time, total_time_next;
  logic [16:0]   check_timer, check_timer_next;
  logic          stuck_flag, stuck_flag_next;
  logic [2:0]    stuck_kind, stuck_kind_next;
  logic [31:0]   stuck_start, stuck_start_next;
  logic [31:0]   stuck_len, stuck_len_next;
  logic [7:0]    fail_count, fail_count_next;
  logic [7:0]    bump_count, bump_count_next;
  logic [15:0]   last_waypoint, last_waypoint_next;
  logic [31:0]   last_progress_time, last_progress_time_next;

  // oldest and newest samples of the ring, kept in flops
  sample_t oldest, oldest_next;
  sample_t newest, newest_next;

  // ring ram and same-address forwarding
  logic          ram_we;
  logic [HW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  sample_t       new_sample;
  logic          byp;
  sample_t       byp_data;
  sample_t       after_head;

  // tick arithmetic
  logic [31:0] tick_total;
  logic [16:0] tick_timer;
  logic        check_due;
  logic        do_write;
  logic        pos_stall_raw;
  logic        pos_stall;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      check_interval_ms   <= RST_CHECK_INTERVAL;
      position_window_ms  <= RST_POSITION_WINDOW;
      distance_threshold  <= RST_DIST_THRESHOLD;
      progress_timeout_ms <= RST_PROGRESS_TMO;
      path_failure_limit  <= RST_PATH_FAIL_LIMIT;
      collision_limit     <= RST_COLLISION_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHECK_INTERVAL:  check_interval_ms   <= cfg_data[15:0];
        REG_POSITION_WINDOW: position_window_ms  <= cfg_data;
        REG_DIST_THRESHOLD:  distance_threshold  <= cfg_data[11:0];
        REG_PROGRESS_TMO:    progress_timeout_ms <= cfg_data;
        REG_PATH_FAIL_LIMIT: path_failure_limit  <= cfg_data[7:0];
        REG_COLLISION_LIMIT: collision_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // squared threshold, registered behind the threshold register; the block does not
  // hold items back until it settles after a write
  always_ff @(posedge clk) begin
    thr_sq <= 24'(distance_threshold) * 24'(distance_threshold);
  end

  // ------------------------------------------------------------- handshake
  assign out_free     = !out_valid || status.ready;
  assign go           = s1_valid && out_free;
  assign cmd.ready    = !s1_valid || out_free;
  assign status.valid = out_valid;
  assign status.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  // ------------------------------------------------------------- ring ram
  assign ram_we    = go && do_write;
  assign ram_raddr = wrap_inc(go ? hist_head_next : hist_head);

  msd_ram #(
    .WIDTH (SW),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hist_head),
    .wdata (new_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read and write of one slot in the same cycle: take the written sample
  always_ff @(posedge clk) begin
    byp      <= ram_we && (ram_raddr == hist_head);
    byp_data <= new_sample;
  end

  assign after_head = byp ? byp_data : sample_t'(ram_rdata);

  // ------------------------------------------------------------ tick math
  always_comb begin
    tick_total = total_time + 32'(s1_item.time_step_ms);
    tick_timer = check_timer + 17'(s1_item.time_step_ms);
    check_due  = tick_timer >= 17'(check_interval_ms);
    do_write   = (s1_item.command == CMD_TICK) && check_due && s1_item.position_valid;
    new_sample = '{x: s1_item.position_x, y: s1_item.position_y,
                   z: s1_item.position_z, t: tick_total};
  end

  // ring view after this tick's sample goes in
  always_comb begin
    oldest_next     = oldest;
    newest_next     = newest;
    hist_count_next = hist_count;
    if (do_write) begin
      newest_next = new_sample;
      if (hist_count == '0) begin
        oldest_next = new_sample;
      end else if (hist_count == COUNT_FULL) begin
        // the oldest slot is overwritten, the next one becomes oldest
        oldest_next = after_head;
      end
      if (hist_count != COUNT_FULL) begin
        hist_count_next = hist_count + CW'(1);
      end
    end
  end

  msd_pos_check u_pos (
    .oldest    (oldest_next),
    .newest    (newest_next),
    .window_ms (position_window_ms),
    .thr_sq    (thr_sq),
    .stalled   (pos_stall_raw)
  );

  // position test needs at least two samples
  assign pos_stall = pos_stall_raw && (hist_count_next >= CW'(2));

  // ---------------------------------------------------------- next state
  always_comb begin
    hist_head_next          = hist_head;
    total_time_next         = total_time;
    check_timer_next        = check_timer;
    stuck_flag_next         = stuck_flag;
    stuck_kind_next         = stuck_kind;
    stuck_start_next        = stuck_start;
    stuck_len_next          = stuck_len;
    fail_count_next         = fail_count;
    bump_count_next         = bump_count;
    last_waypoint_next      = last_waypoint;
    last_progress_time_next = last_progress_time;

    unique case (s1_item.command)
      CMD_TICK: begin
        total_time_next  = tick_total;
        check_timer_next = tick_timer;
        if (stuck_flag) begin
          stuck_len_next = tick_total - stuck_start;
        end
        if (check_due) begin
          check_timer_next = '0;
          if (do_write) begin
            hist_head_next = wrap_inc(hist_head);
          end
          // causes in priority order, only when not already stalled
          if (!stuck_flag) begin
            priority if (pos_stall) begin
              stuck_flag_next = 1'b1;
              stuck_kind_next = KIND_POSITION;
            end else if ((last_progress_time != '0) &&
                         ((tick_total - last_progress_time) >=
                          32'(progress_timeout_ms))) begin
              stuck_flag_next = 1'b1;
              stuck_kind_next = KIND_PROGRESS;
            end else if (fail_count >= path_failure_limit) begin
              stuck_flag_next = 1'b1;
              stuck_kind_next = KIND_PATH_FAIL;
            end else if (bump_count >= collision_limit) begin
              stuck_flag_next = 1'b1;
              stuck_kind_next = KIND_COLLISION;
            end else begin
              stuck_flag_next = 1'b0;
            end
            if (stuck_flag_next) begin
              stuck_start_next = tick_total;
              stuck_len_next   = '0;
            end
          end
        end
      end
      CMD_PATH_FAIL: begin
        if (fail_count != COUNT_MAX) begin
          fail_count_next = fail_count + 8'd1;
        end
      end
      CMD_COLLISION: begin
        if (bump_count != COUNT_MAX) begin
          bump_count_next = bump_count + 8'd1;
        end
      end
      CMD_PROGRESS: begin
        if (s1_item.waypoint_index != last_waypoint) begin
          last_waypoint_next      = s1_item.waypoint_index;
          last_progress_time_next = total_time;
          fail_count_next         = '0;
          bump_count_next         = '0;
          // progress only clears the movement-related stalls
          if (stuck_flag && ((stuck_kind == KIND_POSITION) ||
                             (stuck_kind == KIND_PROGRESS))) begin
            stuck_flag_next  = 1'b0;
            stuck_kind_next  = KIND_NONE;
            stuck_len_next   = '0;
            stuck_start_next = '0;
          end
        end
      end
      CMD_RESET, CMD_CLEAR_HIST: begin
        stuck_flag_next         = 1'b0;
        stuck_kind_next         = KIND_NONE;
        stuck_len_next          = '0;
        stuck_start_next        = '0;
        fail_count_next         = '0;
        bump_count_next         = '0;
        last_progress_time_next = total_time;
        if (s1_item.command == CMD_CLEAR_HIST) begin
          hist_head_next = '0;
        end
      end
      default: ;  // unused codes only report status
    endcase
  end

  // ------------------------------------------------------- state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_head          <= '0;
      hist_count         <= '0;
      total_time         <= '0;
      check_timer        <= '0;
      stuck_flag         <= 1'b0;
      stuck_kind         <= KIND_NONE;
      stuck_start        <= '0;
      stuck_len          <= '0;
      fail_count         <= '0;
      bump_count         <= '0;
      last_waypoint      <= WAYPOINT_NONE;
      last_progress_time <= '0;
    end else if (go) begin
      hist_head          <= hist_head_next;
      // clear history empties the ring
      hist_count         <= (s1_item.command == CMD_CLEAR_HIST) ? '0 : hist_count_next;
      total_time         <= total_time_next;
      check_timer        <= check_timer_next;
      stuck_flag         <= stuck_flag_next;
      stuck_kind         <= stuck_kind_next;
      stuck_start        <= stuck_start_next;
      stuck_len          <= stuck_len_next;
      fail_count         <= fail_count_next;
      bump_count         <= bump_count_next;
      last_waypoint      <= last_waypoint_next;
      last_progress_time <= last_progress_time_next;
    end
  end

  // sample copies and the result register carry no reset
  always_ff @(posedge clk) begin
    if (go) begin
      oldest   <= oldest_next;
      newest   <= newest_next;
      out_item <= '{is_stuck:       stuck_flag_next,
                    stuck_type:     stuck_kind_next,
                    stuck_duration: stuck_len_next,
                    path_failures:  fail_count_next,
                    collisions:     bump_count_next};
    end
  end

  // ------------------------------------------------------------ assertions
  // a stall always carries a cause, and no stall means a clean duration
  a_stall_consistent: assert property (@(posedge clk) disable iff (rst)
    stuck_flag ? (stuck_kind != KIND_NONE)
               : ((stuck_kind == KIND_NONE) && (stuck_len == '0)))
    else $error("stall flag, cause and duration disagree");

  // the ring never holds more samples than slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= COUNT_FULL)
    else $error("history fill count beyond depth");

  // every item leaving the input register shows up as a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid)
    else $error("processed item produced no result");

  // the ring is only written on a due tick with a valid position
  a_write_on_tick: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_valid && (s1_item.command == CMD_TICK) && check_due))
    else $error("history written outside a check tick");

endmodule

[design/msd_ram.sv]
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/msd_pos_check.sv]
module msd_pos_check
  import msd_pkg::*;
(
  input  sample_t     oldest,
  input  sample_t     newest,
  input  logic [19:0] window_ms,
  input  logic [23:0] thr_sq,
  output logic        stalled
);
  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] sx, sy, sz;
  logic [31:0]        span;
  logic [50:0]        d2;

  always_comb begin
    dx = 25'(newest.x) - 25'(oldest.x);
    dy = 25'(newest.y) - 25'(oldest.y);
    dz = 25'(newest.z) - 25'(oldest.z);
    sx = dx * dx;
    sy = dy * dy;
    sz = dz * dz;
    // each square fits in 49 bits
    d2 = 51'(sx[48:0]) + 51'(sy[48:0]) + 51'(sz[48:0]);
    span = newest.t - oldest.t;
    stalled = (span >= 32'(window_ms)) && (d2 < 51'(thr_sq));
  end
endmodule
